@@ rtl/sfls_pkg.sv @@
// Shared types and constants for the sorted first/last search core.
`default_nettype none

package sfls_pkg;

  // Default number of list entries
  localparam int unsigned DefaultDepth = 256;
  // Element and result widths
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 8;

  // Operation codes of an input item
  localparam logic OpAppend = 1'b0;
  localparam logic OpSearch = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    StIdle,
    StProbe,
    StCompare,
    StDone
  } sfls_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic append;    // write the input element into the list
    logic start;     // load target and open the search range
    logic read;      // read the middle element of the range
    logic update;    // compare and narrow the range
    logic out_load;  // capture the result into the output register
  } sfls_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic range_open;  // lo < hi + 1, more probes to do
  } sfls_sts_t;

endpackage

`default_nettype wire

@@ rtl/sfls_ctrl.sv @@
// Controller state machine for the sorted first/last search core.
`default_nettype none

module sfls_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire sfls_pkg::sfls_sts_t sts_i,
  output sfls_pkg::sfls_cmd_t    cmd_o
);

  sfls_pkg::sfls_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  // Output register can take a new result
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sfls_pkg::StIdle: begin
        if (in_valid_i && (operation_i == sfls_pkg::OpSearch)) begin
          state_d = sfls_pkg::StProbe;
        end
      end
      sfls_pkg::StProbe: begin
        state_d = sts_i.range_open ? sfls_pkg::StCompare : sfls_pkg::StDone;
      end
      sfls_pkg::StCompare: begin
        state_d = sfls_pkg::StProbe;
      end
      sfls_pkg::StDone: begin
        if (out_free) begin
          state_d = sfls_pkg::StIdle;
        end
      end
      default: begin
        state_d = sfls_pkg::StIdle;
      end
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready_o       = (state_q == sfls_pkg::StIdle);
    cmd_o.append     = in_ready_o && in_valid_i && (operation_i == sfls_pkg::OpAppend);
    cmd_o.start      = in_ready_o && in_valid_i && (operation_i == sfls_pkg::OpSearch);
    cmd_o.read       = (state_q == sfls_pkg::StProbe) && sts_i.range_open;
    cmd_o.update     = (state_q == sfls_pkg::StCompare);
    cmd_o.out_load   = (state_q == sfls_pkg::StDone) && out_free;
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sfls_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sfls_dp.sv @@
// Datapath for the sorted first/last search core: list memory, range and result.
`default_nettype none

module sfls_dp #(
  parameter int unsigned Depth = sfls_pkg::DefaultDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire sfls_pkg::sfls_cmd_t               cmd_i,
  output sfls_pkg::sfls_sts_t                    sts_o,
  input  wire logic signed [sfls_pkg::DataW-1:0] value_i,
  input  wire logic                              start_new_list_i,
  input  wire logic                              find_last_i,
  output logic                                   found_o,
  output logic [sfls_pkg::PosW-1:0]              position_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned WideW = (AddrW > sfls_pkg::PosW) ? AddrW : sfls_pkg::PosW;

  logic [sfls_pkg::DataW-1:0] mem_q [Depth];
  logic [sfls_pkg::DataW-1:0] rd_q;

  logic [CntW-1:0]  count_q, count_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hp1_q, hp1_d;      // upper bound plus one
  logic signed [sfls_pkg::DataW-1:0] target_q;
  logic             last_q;
  logic             hit_q, hit_d;
  logic [AddrW-1:0] where_q, where_d;
  logic [AddrW-1:0] mid_q;
  logic             found_q;
  logic [sfls_pkg::PosW-1:0] pos_q;

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic             full;
  logic [CntW:0]    mid_sum;
  logic [CntW:0]    mid_half;
  logic [AddrW-1:0] mid;
  logic [CntW-1:0]  mid_plus1;
  logic signed [sfls_pkg::DataW-1:0] elem;
  logic [WideW-1:0] where_wide;

  // Append address and enable
  assign full    = (count_q == CntW'(Depth));
  assign wr_en   = cmd_i.append && (start_new_list_i || !full);
  assign wr_addr = start_new_list_i ? '0 : count_q[AddrW-1:0];

  // Middle of the range
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hp1_q} - (CntW+1)'(1);
  assign mid_half  = mid_sum >> 1;
  assign mid       = mid_half[AddrW-1:0];
  assign mid_plus1 = CntW'(mid_q) + CntW'(1);

  assign sts_o.range_open = (lo_q < hp1_q);
  assign elem             = $signed(rd_q);

  // Count update
  always_comb begin
    count_d = count_q;
    if (cmd_i.append) begin
      if (start_new_list_i) begin
        count_d = CntW'(1);
      end else if (!full) begin
        count_d = count_q + CntW'(1);
      end
    end
  end

  // Range and match update
  always_comb begin
    lo_d    = lo_q;
    hp1_d   = hp1_q;
    hit_d   = hit_q;
    where_d = where_q;
    if (cmd_i.start) begin
      lo_d    = '0;
      hp1_d   = count_q;
      hit_d   = 1'b0;
      where_d = '0;
    end else if (cmd_i.update) begin
      priority if (elem == target_q) begin
        hit_d   = 1'b1;
        where_d = mid_q;
        if (last_q) begin
          lo_d = mid_plus1;
        end else begin
          hp1_d = CntW'(mid_q);
        end
      end else if (elem > target_q) begin
        hp1_d = CntW'(mid_q);
      end else begin
        lo_d = mid_plus1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Search registers
  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hp1_q   <= hp1_d;
    hit_q   <= hit_d;
    where_q <= where_d;
    if (cmd_i.start) begin
      target_q <= value_i;
      last_q   <= find_last_i;
    end
    if (cmd_i.read) begin
      mid_q <= mid;
    end
  end

  // List memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_q <= mem_q[mid];
    end
  end

  // Output register: low bits of the match position
  assign where_wide = WideW'(where_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      found_q <= hit_q;
      pos_q   <= where_wide[sfls_pkg::PosW-1:0];
    end
  end

  assign found_o    = found_q;
  assign position_o = pos_q;

endmodule

`default_nettype wire

@@ rtl/sorted_first_last_search_core.sv @@
// Top level of the sorted first/last search core: controller plus datapath.
//
//   channel | direction | signals
//   --------+-----------+-------------------------------------------------------
//   in      | input     | in_valid_i, in_ready_o, operation_i, value_i,
//           |           | start_new_list_i, find_last_i
//   out     | output    | out_valid_o, out_ready_i, found_o, position_o
//
// An append produces no result. A search over n elements runs
// floor(log2(n)) + 1 probes at most, each a registered read of the list
// memory followed by compare and narrow, plus the accept, exit and result
// load steps. The single read port of the list memory sets the probe pace.
// Reset clears the element count and the control state; the list memory has
// no clear. A stalled result holds the finished search until it is taken.
`default_nettype none

module sorted_first_last_search_core #(
  parameter int unsigned Depth = sfls_pkg::DefaultDepth
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              operation_i,
  input  wire logic signed [sfls_pkg::DataW-1:0] value_i,
  input  wire logic                              start_new_list_i,
  input  wire logic                              find_last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   found_o,
  output logic [sfls_pkg::PosW-1:0]              position_o
);

  sfls_pkg::sfls_cmd_t cmd;
  sfls_pkg::sfls_sts_t sts;

  sfls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sfls_dp #(
    .Depth (Depth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .value_i          (value_i),
    .start_new_list_i (start_new_list_i),
    .find_last_i      (find_last_i),
    .found_o          (found_o),
    .position_o       (position_o)
  );

  // A missed search reports position zero
  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (position_o == '0))
    else $error("miss with nonzero position");

  // A search transfer closes the input until the search is done
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (operation_i == sfls_pkg::OpSearch)) |=> !in_ready_o)
    else $error("input open during search");

  // A result rises only after search work, with the input closed before it
  a_result_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result without search");

endmodule

`default_nettype wire
